// File: src/utfa_pkg.sv
// Shared types, constants and the code point folding function of the UTF-8 to ASCII folder.
`timescale 1ns / 1ps
`default_nettype none
package utfa_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned RUN_MAX = 4;
  localparam int unsigned RUN_CW  = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd255;

  typedef logic [CHAR_W-1:0] chr_t;

  localparam chr_t CH_NUL   = 7'h00;
  localparam chr_t CH_SPACE = 7'h20;
  localparam chr_t CH_DQUOT = 7'h22;
  localparam chr_t CH_APOS  = 7'h27;
  localparam chr_t CH_DASH  = 7'h2D;
  localparam chr_t CH_DOT   = 7'h2E;
  localparam chr_t CH_QMARK = 7'h3F;

  localparam logic [CP_W-1:0] CP_EN_DASH  = 21'h2013;
  localparam logic [CP_W-1:0] CP_EM_DASH  = 21'h2014;
  localparam logic [CP_W-1:0] CP_LSQUO    = 21'h2018;
  localparam logic [CP_W-1:0] CP_RSQUO    = 21'h2019;
  localparam logic [CP_W-1:0] CP_LDQUO    = 21'h201C;
  localparam logic [CP_W-1:0] CP_RDQUO    = 21'h201D;
  localparam logic [CP_W-1:0] CP_ELLIPSIS = 21'h2026;
  localparam logic [CP_W-1:0] CP_NBSP     = 21'h00A0;
  localparam logic [CP_W-1:0] CP_PRINT_LO = 21'h20;
  localparam logic [CP_W-1:0] CP_PRINT_HI = 21'h7E;

  // Characters caused by one byte, first character at index 0.
  typedef struct packed {
    chr_t [RUN_MAX-1:0] chars;
    logic [RUN_CW-1:0]  cnt;
    logic               term;
  } run_t;

  typedef struct packed {
    chr_t ch;
    logic dots;
  } fold_t;

  function automatic fold_t fold_cp(input logic [CP_W-1:0] cp);
    fold_t f;
    f.dots = 1'b0;
    if (cp inside {CP_EN_DASH, CP_EM_DASH}) begin
      f.ch = CH_DASH;
    end else if (cp inside {CP_LSQUO, CP_RSQUO}) begin
      f.ch = CH_APOS;
    end else if (cp inside {CP_LDQUO, CP_RDQUO}) begin
      f.ch = CH_DQUOT;
    end else if (cp == CP_ELLIPSIS) begin
      f.ch   = CH_DOT;
      f.dots = 1'b1;
    end else if (cp == CP_NBSP) begin
      f.ch = CH_SPACE;
    end else if (cp inside {[CP_PRINT_LO:CP_PRINT_HI]}) begin
      f.ch = cp[CHAR_W-1:0];
    end else begin
      f.ch = CH_QMARK;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// File: src/utfa_if.sv
// Handshake interfaces for the byte input channel and the character result channel.
`timescale 1ns / 1ps
`default_nettype none
interface utfa_byte_if;
  import utfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface utfa_char_if;
  import utfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              run_last;
  logic              string_end;
  modport source (output valid, output out_char, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_char, input run_last, input string_end,
                output ready);
endinterface
`default_nettype wire

// File: src/utfa_decode.sv
// Sequence decoder state, output limit register and the per-byte character run logic.
`timescale 1ns / 1ps
`default_nettype none
module utfa_decode (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [utfa_pkg::BYTE_W-1:0]     byte_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [utfa_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  output utfa_pkg::run_t                       run_o
);
  import utfa_pkg::*;

  logic [CP_W-1:0]    pc_q, pc_d;
  logic [1:0]         wanted_q, wanted_d;
  logic [1:0]         taken_q, taken_d;
  logic [LIMIT_W-1:0] count_q, count_d;
  logic [LIMIT_W-1:0] limit_q;

  logic               pend, cont, term;
  logic [CP_W-1:0]    pc_shift;
  logic [1:0]         flush_n;
  logic [1:0]         body_n;
  chr_t               body_ch;
  fold_t              f_seq, f_byte;
  logic [RUN_CW-1:0]  raw_n, emit_n;
  logic [LIMIT_W-1:0] room;

  assign pend     = (wanted_q != 2'd0);
  assign cont     = (byte_i[7:6] == 2'b10);
  assign pc_shift = {pc_q[CP_W-7:0], byte_i[5:0]};
  assign f_seq    = fold_cp(pc_shift);
  assign f_byte   = fold_cp({{(CP_W-BYTE_W){1'b0}}, byte_i});

  always_comb begin
    pc_d     = pc_q;
    wanted_d = wanted_q;
    taken_d  = taken_q;
    flush_n  = 2'd0;
    body_n   = 2'd0;
    body_ch  = CH_QMARK;
    term     = 1'b0;
    if (pend && cont) begin
      pc_d     = pc_shift;
      taken_d  = taken_q + 2'd1;
      wanted_d = wanted_q - 2'd1;
      if (wanted_q == 2'd1) begin
        pc_d    = '0;
        taken_d = 2'd0;
        body_ch = f_seq.ch;
        body_n  = f_seq.dots ? 2'd3 : 2'd1;
      end
    end else begin
      // A broken sequence flushes one '?' per byte taken, then the byte starts afresh.
      if (pend) begin
        flush_n = taken_q;
      end
      pc_d     = '0;
      wanted_d = 2'd0;
      taken_d  = 2'd0;
      if (byte_i == '0) begin
        term = 1'b1;
      end else if (byte_i[7] == 1'b0) begin
        body_ch = f_byte.ch;
        body_n  = 2'd1;
      end else if (byte_i[7:5] == 3'b110) begin
        pc_d     = {{(CP_W-5){1'b0}}, byte_i[4:0]};
        wanted_d = 2'd1;
        taken_d  = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        pc_d     = {{(CP_W-4){1'b0}}, byte_i[3:0]};
        wanted_d = 2'd2;
        taken_d  = 2'd1;
      end else if (byte_i[7:3] == 5'b11110) begin
        pc_d     = {{(CP_W-3){1'b0}}, byte_i[2:0]};
        wanted_d = 2'd3;
        taken_d  = 2'd1;
      end else begin
        body_ch = CH_QMARK;
        body_n  = 2'd1;
      end
    end
  end

  assign raw_n = {1'b0, flush_n} + {1'b0, body_n};
  assign room  = (count_q < limit_q) ? (limit_q - count_q) : '0;

  always_comb begin
    if (room < LIMIT_W'(raw_n)) begin
      emit_n = room[RUN_CW-1:0];
    end else begin
      emit_n = raw_n;
    end
    // Flushed marks come first; only an ellipsis has more than one body character.
    for (int i = 0; i < RUN_MAX; i++) begin
      if (RUN_CW'(i) < {1'b0, flush_n}) begin
        run_o.chars[i] = CH_QMARK;
      end else if (RUN_CW'(i) == {1'b0, flush_n}) begin
        run_o.chars[i] = body_ch;
      end else begin
        run_o.chars[i] = CH_DOT;
      end
      if (term && (RUN_CW'(i) == emit_n)) begin
        run_o.chars[i] = CH_NUL;
      end
    end
    run_o.cnt  = emit_n + {{(RUN_CW-1){1'b0}}, term};
    run_o.term = term;
    count_d    = term ? '0 : (count_q + LIMIT_W'(emit_n));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      wanted_q <= 2'd0;
      taken_q  <= 2'd0;
      count_q  <= '0;
    end else if (accept_i) begin
      pc_q     <= pc_d;
      wanted_q <= wanted_d;
      taken_q  <= taken_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: src/utf8_to_ascii_folder_top.sv
// Top level of the UTF-8 to printable ASCII folder: byte decoder and result run buffer.
//
// text_i takes one UTF-8 byte per item; char_o gives one ASCII character per item,
// with run_last marking the last character caused by a byte and string_end marking
// the terminator that a zero byte produces. The user must write the output limit
// register through cfg_we_i / cfg_wdata_i only while the block is idle; the block
// itself does not enforce this. The limit resets to 255. A byte is decoded in the
// cycle it is accepted and its characters are loaded into a four-entry run buffer,
// so the first character appears in the cycle after accept. A new byte is accepted
// in the same cycle that the last buffered character is taken. A byte causing n
// characters occupies the buffer until its last character is taken; n is at most
// four, for a broken sequence followed by a character or a terminator. A byte that
// causes no character leaves the buffer empty. When the receiver stalls, the
// buffered character holds and text_i.ready drops until the last character of the
// run is taken. Reset clears the pending sequence, the per-string count and the buffer.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_ascii_folder_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  utfa_byte_if.sink                         text_i,
  utfa_char_if.source                       char_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [utfa_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import utfa_pkg::*;

  run_t               run;
  logic               accept, take;
  chr_t [RUN_MAX-1:0] chars_q;
  logic [RUN_CW-1:0]  n_q;
  logic               term_q;

  assign take         = char_o.valid && char_o.ready;
  assign text_i.ready = (n_q == '0) || ((n_q == RUN_CW'(1)) && char_o.ready);
  assign accept       = text_i.valid && text_i.ready;

  utfa_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (text_i.text_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .run_o       (run)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (accept) begin
      n_q <= run.cnt;
    end else if (take) begin
      n_q <= n_q - RUN_CW'(1);
    end
  end

  // The head of the buffer is always the character on offer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chars_q <= run.chars;
      term_q  <= run.term;
    end else if (take) begin
      for (int i = 0; i < RUN_MAX - 1; i++) begin
        chars_q[i] <= chars_q[i+1];
      end
    end
  end

  assign char_o.valid      = (n_q != '0);
  assign char_o.out_char   = chars_q[0];
  assign char_o.run_last   = (n_q == RUN_CW'(1));
  assign char_o.string_end = term_q && (n_q == RUN_CW'(1));

endmodule
`default_nettype wire

// File: src/utfa_checker.sv
// Port-level assertions for the UTF-8 to ASCII folder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module utfa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [utfa_pkg::CHAR_W-1:0] out_char_i,
  input wire logic                        run_last_i,
  input wire logic                        string_end_i
);
  import utfa_pkg::*;

  // A stalled item keeps its character and flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(run_last_i)
      && $stable(string_end_i))
    else $error("stalled result item changed");

  // The terminator is a NUL and always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> (out_char_i == CH_NUL) && run_last_i)
    else $error("terminator item malformed");

  // No new byte is taken while more characters of the current run are queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !run_last_i |-> !in_ready_i)
    else $error("byte accepted in the middle of a run");

  // Every character that is not a terminator is printable.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !string_end_i |-> (out_char_i >= CP_PRINT_LO[CHAR_W-1:0])
      && (out_char_i <= CP_PRINT_HI[CHAR_W-1:0]))
    else $error("non-printable character emitted");

endmodule

bind utf8_to_ascii_folder_top utfa_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (text_i.ready),
  .out_valid_i  (char_o.valid),
  .out_ready_i  (char_o.ready),
  .out_char_i   (char_o.out_char),
  .run_last_i   (char_o.run_last),
  .string_end_i (char_o.string_end)
);
`default_nettype wire
